/* rtl/core/aes_pkg.sv */
// Shared types, constants and GF(2^8) helpers for the AES block cipher.
package aes_pkg;

   // Key size codes held in the key_size register.
   localparam logic [1:0] KS_128 = 2'd0;
   localparam logic [1:0] KS_192 = 2'd1;
   localparam logic [1:0] KS_256 = 2'd2;
   localparam logic [1:0] KS_RSVD = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_KEY_SIZE  = 3'd0;
   localparam logic [2:0] CSR_KEY_PART0 = 3'd1;
   localparam logic [2:0] CSR_KEY_PART1 = 3'd2;
   localparam logic [2:0] CSR_KEY_PART2 = 3'd3;
   localparam logic [2:0] CSR_KEY_PART3 = 3'd4;

   localparam logic [7:0] GF_POLY = 8'h1b;
   localparam logic [7:0] RCON_FIRST = 8'h01;

   // Control passed with each round.
   typedef struct packed {
      logic decrypt;
      logic last;
   } rnd_ctl_type;

   // Forward S-box, entry 0 in the top byte.
   localparam logic [2047:0] SBOX_BITS = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16
   };

   function automatic logic [2047:0] build_inv_sbox();
      logic [2047:0] r;
      logic [7:0]    b;
      r = '0;
      for (int i = 0; i < 256; i++) begin
         b = SBOX_BITS[2047 - 8 * i -: 8];
         r[2047 - 8 * int'(b) -: 8] = 8'(i);
      end
      return r;
   endfunction

   localparam logic [2047:0] INV_SBOX_BITS = build_inv_sbox();

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_BITS[(11'd2047 - {x, 3'b000}) -: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      return INV_SBOX_BITS[(11'd2047 - {x, 3'b000}) -: 8];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3;
      a0 = c[31:24];
      a1 = c[23:16];
      a2 = c[15:8];
      a3 = c[7:0];
      return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
              a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
              a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
              xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
   endfunction

   // Multiples 9, 11, 13, 14 packed as {m14, m13, m11, m9}.
   function automatic logic [31:0] inv_mults(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a);
      x4 = xtime(x2);
      x8 = xtime(x4);
      return {x8 ^ x4 ^ x2, x8 ^ x4 ^ a, x8 ^ x2 ^ a, x8 ^ a};
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
      logic [31:0] m0, m1, m2, m3;
      m0 = inv_mults(c[31:24]);
      m1 = inv_mults(c[23:16]);
      m2 = inv_mults(c[15:8]);
      m3 = inv_mults(c[7:0]);
      // fields: [31:24]=14, [23:16]=13, [15:8]=11, [7:0]=9
      return {m0[31:24] ^ m1[15:8] ^ m2[23:16] ^ m3[7:0],
              m0[7:0] ^ m1[31:24] ^ m2[15:8] ^ m3[23:16],
              m0[23:16] ^ m1[7:0] ^ m2[31:24] ^ m3[15:8],
              m0[15:8] ^ m1[23:16] ^ m2[7:0] ^ m3[31:24]};
   endfunction

endpackage

/* rtl/core/aes_round.sv */
// One AES round, forward or inverse, shared by every round of a block.
module aes_round (
   input  logic [127:0]        state_in,
   input  logic [127:0]        round_key,
   input  aes_pkg::rnd_ctl_type ctl,
   output logic [127:0]        state_out
);

   logic [7:0]   b_in  [16];
   logic [7:0]   b_sub [16];
   logic [127:0] sub_st;
   logic [127:0] keyed;
   logic [127:0] mixed;
   int           src;

   always_comb begin
      src = 0;
      for (int i = 0; i < 16; i++) begin
         b_in[i] = state_in[127 - 8 * i -: 8];
      end
      // shift rows, then substitute (both are bytewise, order is free)
      for (int i = 0; i < 16; i++) begin
         if (ctl.decrypt) begin
            src = 4 * (((i / 4) + 4 - (i % 4)) % 4) + (i % 4);
            b_sub[i] = aes_pkg::inv_sbox(b_in[src]);
         end else begin
            src = 4 * (((i / 4) + (i % 4)) % 4) + (i % 4);
            b_sub[i] = aes_pkg::sbox(b_in[src]);
         end
      end
      for (int i = 0; i < 16; i++) begin
         sub_st[127 - 8 * i -: 8] = b_sub[i];
      end
      keyed = sub_st ^ round_key;
      for (int c = 0; c < 4; c++) begin
         if (ctl.decrypt) begin
            mixed[127 - 32 * c -: 32] = aes_pkg::inv_mix_col(keyed[127 - 32 * c -: 32]);
         end else begin
            mixed[127 - 32 * c -: 32] = aes_pkg::mix_col(sub_st[127 - 32 * c -: 32]);
         end
      end
      if (ctl.last) begin
         state_out = keyed;
      end else if (ctl.decrypt) begin
         state_out = mixed;
      end else begin
         state_out = mixed ^ round_key;
      end
   end

endmodule

/* rtl/core/aes_block_cipher.sv */
// AES-128/192/256 block cipher: one shared round unit under a small sequencer.
// Blocks run Nr rounds (Nr = 10, 12 or 14); key expansion runs first on the first block
//   after reset or a csr write, and a new block is accepted only while idle.
// The single round unit does one round a cycle unless the final round waits on rsp_ready.
// Reset: synchronous; clears the sequencer, key registers and schedule-valid flag.
//   The round key memory holds no reset value and is rebuilt before any use.
module aes_block_cipher #(
   parameter int SCHEDULE_WORDS = 60
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [63:0] req_block_hi,
   input  logic [63:0] req_block_lo,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_hi,
   output logic [63:0] rsp_result_lo,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int ROWS  = (SCHEDULE_WORDS + 3) / 4;
   localparam int ROW_W = $clog2(ROWS);
   localparam int IDX_W = $clog2(SCHEDULE_WORDS);
   // Largest key size whose schedule fits in the memory.
   localparam logic [1:0] MAX_KS = (SCHEDULE_WORDS >= 60) ? aes_pkg::KS_256 :
                                   (SCHEDULE_WORDS >= 52) ? aes_pkg::KS_192 :
                                   aes_pkg::KS_128;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_START,
      ST_ADD0,
      ST_ROUND
   } state_type;

   state_type    state_ff, state_in;
   logic [1:0]   key_size_ff, key_size_in;
   logic [63:0]  key_part_ff [4];
   logic [63:0]  key_part_in [4];
   logic         sched_ready_ff, sched_ready_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;
   logic [127:0] blk_ff, blk_in;
   logic         dec_ff, dec_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [2:0]   mod_ff, mod_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [31:0]  win_ff [8];
   logic [31:0]  win_in [8];
   logic [127:0] rk_ff;

   logic [127:0] key_mem [ROWS];
   logic         mem_we;
   logic [ROW_W-1:0] mem_waddr;
   logic [127:0] mem_wdata;

   logic [1:0]   ks_req, ks_eff;
   logic [3:0]   nr, nk;
   logic [ROW_W-1:0] nr_row;
   logic [31:0]  key_word, older, prev, tmp, new_word;
   logic [63:0]  part_sel;
   logic         rnd_last;
   aes_pkg::rnd_ctl_type rnd_ctl;
   logic [127:0] rnd_out;

   // Effective key size: reserved code acts as 256-bit, then clip to memory depth.
   always_comb begin
      ks_req = (key_size_ff == aes_pkg::KS_RSVD) ? aes_pkg::KS_256 : key_size_ff;
      ks_eff = (ks_req > MAX_KS) ? MAX_KS : ks_req;
      nr     = 4'd10 + {1'b0, ks_eff, 1'b0};
      nk     = 4'd4 + {1'b0, ks_eff, 1'b0};
      nr_row = ROW_W'(nr);
   end

   // Key expansion word, one per cycle.
   always_comb begin
      part_sel = key_part_ff[idx_ff[2:1]];
      key_word = idx_ff[0] ? part_sel[31:0] : part_sel[63:32];
      unique case (ks_eff)
         aes_pkg::KS_256: older = win_ff[0];
         aes_pkg::KS_192: older = win_ff[2];
         default:         older = win_ff[4];
      endcase
      prev = win_ff[7];
      if (mod_ff == 3'd0) begin
         tmp = aes_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (ks_eff == aes_pkg::KS_256 && mod_ff == 3'd4) begin
         tmp = aes_pkg::sub_word(prev);
      end else begin
         tmp = prev;
      end
      new_word = (idx_ff < IDX_W'(nk)) ? key_word : (older ^ tmp);
   end

   assign rnd_last = dec_ff ? (row_ff == '0) : (row_ff == nr_row);
   assign rnd_ctl  = '{decrypt: dec_ff, last: rnd_last};

   aes_round u_round (
      .state_in  (blk_ff),
      .round_key (rk_ff),
      .ctl       (rnd_ctl),
      .state_out (rnd_out)
   );

   // Sequencer next-state logic.
   always_comb begin
      state_in       = state_ff;
      key_size_in    = key_size_ff;
      key_part_in    = key_part_ff;
      sched_ready_in = sched_ready_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      blk_in         = blk_ff;
      dec_in         = dec_ff;
      row_in         = row_ff;
      idx_in         = idx_ff;
      mod_in         = mod_ff;
      rcon_in        = rcon_ff;
      win_in         = win_ff;
      mem_we         = 1'b0;
      mem_waddr      = ROW_W'(idx_ff[IDX_W-1:2]);
      mem_wdata      = {win_ff[5], win_ff[6], win_ff[7], new_word};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               blk_in = {req_block_hi, req_block_lo};
               dec_in = req_mode;
               if (sched_ready_ff) begin
                  // fetch first round key now, it lands in rk_ff next cycle
                  row_in   = req_mode ? nr_row : '0;
                  state_in = ST_ADD0;
               end else begin
                  idx_in   = '0;
                  mod_in   = 3'd0;
                  rcon_in  = aes_pkg::RCON_FIRST;
                  state_in = ST_EXPAND;
               end
            end
         end
         ST_EXPAND: begin
            for (int j = 0; j < 7; j++) begin
               win_in[j] = win_ff[j + 1];
            end
            win_in[7] = new_word;
            mem_we    = (idx_ff[1:0] == 2'd3);
            if (idx_ff >= IDX_W'(nk) && mod_ff == 3'd0) begin
               rcon_in = aes_pkg::xtime(rcon_ff);
            end
            mod_in = (mod_ff == 3'(nk - 4'd1)) ? 3'd0 : mod_ff + 3'd1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'({nr, 2'b11})) begin
               sched_ready_in = 1'b1;
               state_in       = ST_START;
            end
         end
         ST_START: begin
            // separate cycle so the read never collides with the last row write
            row_in   = dec_ff ? nr_row : '0;
            state_in = ST_ADD0;
         end
         ST_ADD0: begin
            blk_in   = blk_ff ^ rk_ff;
            row_in   = dec_ff ? row_ff - 1'b1 : row_ff + 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (!rnd_last) begin
               blk_in = rnd_out;
               row_in = dec_ff ? row_ff - 1'b1 : row_ff + 1'b1;
            end else if (!rsp_valid_ff || rsp_ready) begin
               // hold the final round until the output register frees
               rsp_data_in  = rnd_out;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // csr writes are expected only while idle; any valid index drops the schedule
      if (csr_write_en) begin
         case (csr_index) inside
            aes_pkg::CSR_KEY_SIZE: begin
               key_size_in    = csr_data[1:0];
               sched_ready_in = 1'b0;
            end
            aes_pkg::CSR_KEY_PART0, aes_pkg::CSR_KEY_PART1,
            aes_pkg::CSR_KEY_PART2, aes_pkg::CSR_KEY_PART3: begin
               key_part_in[2'(csr_index - aes_pkg::CSR_KEY_PART0)] = csr_data;
               sched_ready_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         key_size_ff    <= aes_pkg::KS_128;
         key_part_ff    <= '{default: '0};
         sched_ready_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         key_size_ff    <= key_size_in;
         key_part_ff    <= key_part_in;
         sched_ready_ff <= sched_ready_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      blk_ff      <= blk_in;
      dec_ff      <= dec_in;
      row_ff      <= row_in;
      idx_ff      <= idx_in;
      mod_ff      <= mod_in;
      rcon_ff     <= rcon_in;
      win_ff      <= win_in;
   end

   // Round key memory: one row write, one registered row read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= mem_wdata;
      end
      rk_ff <= key_mem[row_in];
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_hi = rsp_data_ff[127:64];
   assign rsp_result_lo = rsp_data_ff[63:0];

   // Any write to a mapped register must force a fresh expansion.
   a_csr_drops_sched: assert property (@(posedge clock) disable iff (reset)
      (csr_write_en && csr_index <= aes_pkg::CSR_KEY_PART3) |=> !sched_ready_ff)
      else $error("schedule still marked ready after key register write");

   // Round row stays within the schedule of the active key size.
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (row_ff <= nr_row))
      else $error("round key row out of range");

   // A transfer on the request side starts work.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted block did not start");

   // Finishing a block always leaves a result waiting.
   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_last && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("final round produced no result");

endmodule

/* bench/tb_top.sv */
// Self-checking regression bench for the AES block cipher against FIPS-197 behavior.
`timescale 1ns / 100ps

module tb_top;

   // Register indexes past the mapped list: writes there must be dropped.
   localparam logic [2:0] CSR_UNMAPPED_FIRST = 3'd5;
   localparam logic [2:0] CSR_UNMAPPED_LAST  = 3'd7;
   localparam logic       MODE_ENCRYPT = 1'b0;
   localparam logic       MODE_DECRYPT = 1'b1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [63:0] req_block_hi;
   logic [63:0] req_block_lo;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_result_hi;
   logic [63:0] rsp_result_lo;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   aes_block_cipher dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_block_hi (req_block_hi),
      .req_block_lo (req_block_lo),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_result_hi(rsp_result_hi),
      .rsp_result_lo(rsp_result_lo),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // Expected output blocks, oldest first, and the running mismatch count.
   logic [127:0] pending_blocks[$];
   int           mismatches;
   // When set, neither side inserts idle cycles (back-to-back stretches).
   bit           steady;

   // ---------------------------------------------------------------------
   // Cipher predictor: own S-boxes, own key schedule, own round functions.
   // ---------------------------------------------------------------------
   logic [7:0]  fwd_box[256];
   logic [7:0]  rev_box[256];
   logic [1:0]  key_size_reg;
   logic [63:0] key_reg[4];
   logic [31:0] sched_words[60];
   int          round_count;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   // Affine transform of the multiplicative inverse, per the standard.
   function automatic void build_boxes();
      logic [7:0] inv;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++)
            if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
         fwd_box[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4)
                      ^ 8'h63;
      end
      for (int x = 0; x < 256; x++) rev_box[fwd_box[x]] = 8'(x);
   endfunction

   function automatic void expand_key();
      int         size_code, nk, total;
      logic [7:0] rcon;
      logic [31:0] t;
      // Reserved size code behaves as a 256-bit key.
      size_code = (key_size_reg == aes_pkg::KS_RSVD) ? 2 : int'(key_size_reg);
      nk = 4 + 2 * size_code;
      round_count = 10 + 2 * size_code;
      total = 4 * (round_count + 1);
      rcon = 8'h01;
      for (int i = 0; i < nk; i++)
         sched_words[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
      for (int i = nk; i < total; i++) begin
         t = sched_words[i - 1];
         if (i % nk == 0) begin
            t = {t[23:0], t[31:24]};
            t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]}
                ^ {rcon, 24'h0};
            rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
         end else if (nk > 6 && i % nk == 4) begin
            t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
         end
         sched_words[i] = sched_words[i - nk] ^ t;
      end
   endfunction

   // State byte i sits at bits 127-8i; column c holds bytes 4c..4c+3.
   function automatic logic [127:0] add_key(input logic [127:0] s, input int rnd);
      for (int c = 0; c < 4; c++) s[127 - 32 * c -: 32] ^= sched_words[4 * rnd + c];
      return s;
   endfunction

   function automatic logic [127:0] sub_bytes(input logic [127:0] s, input bit inv);
      for (int i = 0; i < 16; i++)
         s[127 - 8 * i -: 8] = inv ? rev_box[s[127 - 8 * i -: 8]] : fwd_box[s[127 - 8 * i -: 8]];
      return s;
   endfunction

   function automatic logic [127:0] shift_rows(input logic [127:0] s, input bit inv);
      logic [127:0] t;
      int           src;
      t = s;
      for (int c = 0; c < 4; c++)
         for (int r = 1; r < 4; r++) begin
            src = inv ? (c + 4 - r) & 3 : (c + r) & 3;
            s[127 - 8 * (4 * c + r) -: 8] = t[127 - 8 * (4 * src + r) -: 8];
         end
      return s;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s, input bit inv);
      logic [7:0] coef[4];
      logic [7:0] col[4];
      logic [7:0] v;
      if (inv) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else     coef = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) col[k] = s[127 - 8 * (4 * c + k) -: 8];
         for (int r = 0; r < 4; r++) begin
            v = 8'h00;
            for (int k = 0; k < 4; k++) v ^= gf_mul(col[k], coef[(k + 4 - r) & 3]);
            s[127 - 8 * (4 * c + r) -: 8] = v;
         end
      end
      return s;
   endfunction

   function automatic logic [127:0] cipher_block(input logic mode, input logic [127:0] blk);
      expand_key();
      if (mode == MODE_ENCRYPT) begin
         blk = add_key(blk, 0);
         for (int rnd = 1; rnd < round_count; rnd++)
            blk = add_key(mix_columns(shift_rows(sub_bytes(blk, 0), 0), 0), rnd);
         blk = add_key(shift_rows(sub_bytes(blk, 0), 0), round_count);
      end else begin
         blk = add_key(blk, round_count);
         for (int rnd = round_count - 1; rnd >= 1; rnd--)
            blk = mix_columns(add_key(sub_bytes(shift_rows(blk, 1), 1), rnd), 1);
         blk = add_key(sub_bytes(shift_rows(blk, 1), 1), 0);
      end
      return blk;
   endfunction

   // ---------------------------------------------------------------------
   // Clock, limit
   // ---------------------------------------------------------------------
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Allow about ten times the slowest legal run, including key expansion.
   initial begin
      #20_000_000;
      $display("aes_block_cipher regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request and CSR drivers
   // ---------------------------------------------------------------------
   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic logic [63:0] draw_word();
      case ($urandom_range(0, 7))
         0: return 64'h0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Present one block and hold it until the transfer; predict on accept.
   // Valid is only lowered when an idle gap follows, so it never toggles
   // twice in one step.
   task automatic send_block(input logic mode, input logic [63:0] hi, input logic [63:0] lo,
                             input bit known, input logic [127:0] known_blk);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_block_hi <= hi;
      req_block_lo <= lo;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_blocks.push_back(known ? known_blk : cipher_block(mode, {hi, lo}));
   endtask

   // Drop valid and wait for every expected block to come back; always
   // advance at least one edge so the next driver step starts fresh.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_blocks.size() != 0) @(posedge clock);
   endtask

   // Raise the write strobe for one edge; the caller lowers it after a group.
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
      case (idx)
         aes_pkg::CSR_KEY_SIZE:  key_size_reg = data[1:0];
         aes_pkg::CSR_KEY_PART0: key_reg[0] = data;
         aes_pkg::CSR_KEY_PART1: key_reg[1] = data;
         aes_pkg::CSR_KEY_PART2: key_reg[2] = data;
         aes_pkg::CSR_KEY_PART3: key_reg[3] = data;
         default: ;
      endcase
   endtask

   task automatic load_key(input logic [63:0] size, input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
      drain();
      csr_write(aes_pkg::CSR_KEY_SIZE, size);
      csr_write(aes_pkg::CSR_KEY_PART0, k0);
      csr_write(aes_pkg::CSR_KEY_PART1, k1);
      csr_write(aes_pkg::CSR_KEY_PART2, k2);
      csr_write(aes_pkg::CSR_KEY_PART3, k3);
      // Unmapped index: must leave the key untouched.
      csr_write(3'($urandom_range(CSR_UNMAPPED_FIRST, CSR_UNMAPPED_LAST)), draw_word());
      csr_write_en <= 1'b0;
   endtask

   // Directed stimulus: FIPS-197 vectors where the answer is known by sight, plus rows left to the predictor.
   typedef struct {
      bit          reload;
      logic [63:0] size;
      logic [63:0] key[4];
      logic        mode;
      logic [63:0] hi;
      logic [63:0] lo;
      bit          known;
      logic [127:0] result;
   } vector_row_type;

   localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
   localparam logic [127:0] PT_STD = 128'h00112233445566778899aabbccddeeff;
   localparam logic [127:0] CT_128 = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
   localparam logic [127:0] CT_192 = 128'hdda97ca4864cdfe06eaf70a0ec0d7191;
   localparam logic [127:0] CT_256 = 128'h8ea2b7ca516745bfeafc49904b496089;
   localparam logic [127:0] CT_ZERO = 128'h66e94bd4ef8a2c3b884cfa59ca342b2e;
   localparam logic [63:0] K0 = 64'h0001020304050607;
   localparam logic [63:0] K1 = 64'h08090a0b0c0d0e0f;
   localparam logic [63:0] K2 = 64'h1011121314151617;
   localparam logic [63:0] K3 = 64'h18191a1b1c1d1e1f;

   vector_row_type vectors[] = '{
      // Reset key (all zero, 128-bit) without any write.
      '{0, 0, '{0, 0, 0, 0}, MODE_ENCRYPT, 0, 0, 1, CT_ZERO},
      '{0, 0, '{0, 0, 0, 0}, MODE_DECRYPT, CT_ZERO[127:64], CT_ZERO[63:0], 1, 128'h0},
      '{1, aes_pkg::KS_128, '{K0, K1, ONES, ONES}, MODE_ENCRYPT, PT_STD[127:64],
        PT_STD[63:0], 1, CT_128},
      '{0, 0, '{0, 0, 0, 0}, MODE_DECRYPT, CT_128[127:64], CT_128[63:0], 1, PT_STD},
      '{0, 0, '{0, 0, 0, 0}, MODE_ENCRYPT, ONES, ONES, 0, 0},
      // Key part 3 is ignored for a 192-bit key.
      '{1, aes_pkg::KS_192, '{K0, K1, K2, ONES}, MODE_ENCRYPT, PT_STD[127:64],
        PT_STD[63:0], 1, CT_192},
      '{0, 0, '{0, 0, 0, 0}, MODE_DECRYPT, CT_192[127:64], CT_192[63:0], 1, PT_STD},
      '{1, aes_pkg::KS_256, '{K0, K1, K2, K3}, MODE_ENCRYPT, PT_STD[127:64],
        PT_STD[63:0], 1, CT_256},
      '{0, 0, '{0, 0, 0, 0}, MODE_DECRYPT, CT_256[127:64], CT_256[63:0], 1, PT_STD},
      // Reserved size code acts as a 256-bit key.
      '{1, aes_pkg::KS_RSVD, '{K0, K1, K2, K3}, MODE_ENCRYPT, PT_STD[127:64],
        PT_STD[63:0], 1, CT_256},
      '{0, 0, '{0, 0, 0, 0}, MODE_DECRYPT, CT_256[127:64], CT_256[63:0], 1, PT_STD},
      '{1, aes_pkg::KS_256, '{ONES, ONES, ONES, ONES}, MODE_ENCRYPT, ONES, ONES, 0, 0},
      '{0, 0, '{0, 0, 0, 0}, MODE_DECRYPT, 0, 0, 0, 0},
      '{0, 0, '{0, 0, 0, 0}, MODE_DECRYPT, ONES, ONES, 0, 0},
      '{1, aes_pkg::KS_192, '{ONES, ONES, ONES, 0}, MODE_ENCRYPT, 0, ONES, 0, 0},
      // Upper data bits of the size write are dropped: this is a 128-bit key.
      '{1, 64'hffff_ffff_ffff_fffc, '{ONES, ONES, K2, K3}, MODE_ENCRYPT, ONES, 0, 0, 0},
      '{0, 0, '{0, 0, 0, 0}, MODE_DECRYPT, ONES, 0, 0, 0}
   };

   // Main stimulus: reset, directed table, then random key phases.
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_mode     = 1'b0;
      req_block_hi = '0;
      req_block_lo = '0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      mismatches   = 0;
      steady       = 1'b0;
      key_size_reg = aes_pkg::KS_128;
      key_reg      = '{default: '0};
      build_boxes();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[i]) begin
         if (vectors[i].reload)
            load_key(vectors[i].size, vectors[i].key[0], vectors[i].key[1],
                     vectors[i].key[2], vectors[i].key[3]);
         send_block(vectors[i].mode, vectors[i].hi, vectors[i].lo,
                    vectors[i].known, vectors[i].result);
      end

      for (int phase = 0; phase < 20; phase++) begin
         drain();
         steady = ($urandom_range(0, 3) == 0);
         // Rewrite a random subset of registers; size covers all four codes.
         if ($urandom_range(0, 1)) csr_write(aes_pkg::CSR_KEY_SIZE, {$urandom, $urandom});
         if ($urandom_range(0, 1)) csr_write(aes_pkg::CSR_KEY_PART0, draw_word());
         if ($urandom_range(0, 1)) csr_write(aes_pkg::CSR_KEY_PART1, draw_word());
         if ($urandom_range(0, 1)) csr_write(aes_pkg::CSR_KEY_PART2, draw_word());
         if ($urandom_range(0, 1)) csr_write(aes_pkg::CSR_KEY_PART3, draw_word());
         if ($urandom_range(0, 3) == 0)
            csr_write(3'($urandom_range(CSR_UNMAPPED_FIRST, CSR_UNMAPPED_LAST)), draw_word());
         csr_write_en <= 1'b0;
         for (int n = 0; n < 80; n++)
            send_block(1'($urandom_range(0, 1)), draw_word(), draw_word(), 0, 0);
      end

      drain();
      // Nothing outstanding; give the block time to show any stray output.
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("aes_block_cipher regression: pass");
      end else begin
         $display("aes_block_cipher regression: fail");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: random stalls, check each transfer against the oldest
   // expectation.
   // ---------------------------------------------------------------------
   initial begin
      logic [127:0] want;
      int           stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_blocks.size() == 0) begin
            $display("%0t: unexpected result %h_%h", $realtime, rsp_result_hi, rsp_result_lo);
            mismatches++;
         end else begin
            want = pending_blocks.pop_front();
            if (rsp_result_hi !== want[127:64]) begin
               $display("%0t: result_hi expected %h actual %h", $realtime, want[127:64],
                        rsp_result_hi);
               mismatches++;
            end
            if (rsp_result_lo !== want[63:0]) begin
               $display("%0t: result_lo expected %h actual %h", $realtime, want[63:0],
                        rsp_result_lo);
               mismatches++;
            end
         end
      end
   end

endmodule
